### rtl/mer_pkg.sv
package mer_pkg;

  localparam int CENTER_MAX = 1023;
  localparam int RADIUS_MAX = 511;

  localparam int CTR_W   = 10;
  localparam int RAD_W   = 9;
  localparam int SQ_W    = 18;
  localparam int XOFF_W  = 10;
  localparam int TERM_W  = 29;
  localparam int DEC_W   = 44;
  localparam int MUL_W   = 22;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int COORD_W = 12;
  localparam int PC_W    = 5;

  localparam logic OPER_START = 1'b0;

  typedef enum logic [1:0] {
    PH_DONE = 2'd0,
    PH_R1   = 2'd1,
    PH_R2   = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    OP_ONE, OP_RX, OP_RY, OP_RX2, OP_RY2, OP_T, OP_AODD, OP_BTERM
  } opsel_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD
  } accop_t;

  typedef enum logic [2:0] {
    WALK_NONE, WALK_R1A, WALK_R1B, WALK_R2A, WALK_R2B
  } walk_t;

  typedef enum logic [2:0] {
    C_NEVER, C_ALWAYS, C_IN_START, C_NOT_R1, C_NOT_R2, C_XS_GE_YS, C_Y_ZERO
  } cond_t;

  typedef enum logic [1:0] {
    EMIT_NONE, EMIT_POINT, EMIT_DONE
  } emit_t;

  typedef struct packed {
    logic            wait_in;
    cond_t           cond;
    logic [PC_W-1:0] target;
    opsel_t          ma;
    opsel_t          mb;
    logic            wr_rx2;
    logic            wr_ry2;
    logic            wr_t;
    accop_t          acc_op;
    logic            acc_neg;
    logic            acc_shl2;
    logic            ys_load;
    logic            d_load;
    walk_t           walk;
    logic            set_phase;
    phase_t          phase_val;
    emit_t           emit;
  } uc_t;

  typedef struct packed {
    uc_t  word;
    logic en;
  } ctl_t;

  typedef struct packed {
    logic in_valid;
    logic in_start;
    logic out_busy;
    logic not_r1;
    logic not_r2;
    logic xs_ge_ys;
    logic y_zero;
  } stat_t;

  localparam logic [PC_W-1:0] A_WAIT  = PC_W'(0);
  localparam logic [PC_W-1:0] A_ADV   = PC_W'(1);
  localparam logic [PC_W-1:0] A_R1CHK = PC_W'(2);
  localparam logic [PC_W-1:0] A_R1A   = PC_W'(3);
  localparam logic [PC_W-1:0] A_R1B   = PC_W'(4);
  localparam logic [PC_W-1:0] A_SW0   = PC_W'(5);
  localparam logic [PC_W-1:0] A_SW1   = PC_W'(6);
  localparam logic [PC_W-1:0] A_SW2   = PC_W'(7);
  localparam logic [PC_W-1:0] A_SW3   = PC_W'(8);
  localparam logic [PC_W-1:0] A_SW4   = PC_W'(9);
  localparam logic [PC_W-1:0] A_SW5   = PC_W'(10);
  localparam logic [PC_W-1:0] A_SW6   = PC_W'(11);
  localparam logic [PC_W-1:0] A_R2    = PC_W'(12);
  localparam logic [PC_W-1:0] A_R2CHK = PC_W'(13);
  localparam logic [PC_W-1:0] A_R2A   = PC_W'(14);
  localparam logic [PC_W-1:0] A_R2B   = PC_W'(15);
  localparam logic [PC_W-1:0] A_DONE  = PC_W'(16);
  localparam logic [PC_W-1:0] A_ST0   = PC_W'(17);
  localparam logic [PC_W-1:0] A_ST1   = PC_W'(18);
  localparam logic [PC_W-1:0] A_ST2   = PC_W'(19);
  localparam logic [PC_W-1:0] A_ST3   = PC_W'(20);
  localparam logic [PC_W-1:0] A_ST4   = PC_W'(21);
  localparam logic [PC_W-1:0] A_ST5   = PC_W'(22);
  localparam logic [PC_W-1:0] A_ST6   = PC_W'(23);

  function automatic logic [CTR_W-1:0] sat_center(input logic [CTR_W-1:0] v);
    return (v > CTR_W'(CENTER_MAX)) ? CTR_W'(CENTER_MAX) : v;
  endfunction

  function automatic logic [RAD_W-1:0] sat_radius(input logic [RAD_W-1:0] v);
    return (v > RAD_W'(RADIUS_MAX)) ? RAD_W'(RADIUS_MAX) : v;
  endfunction

  // control store
  function automatic uc_t uc_rom(input logic [PC_W-1:0] a);
    uc_t w;
    w = '0;
    case (a)
      A_WAIT: begin
        w.wait_in = 1'b1;
        w.cond    = C_IN_START;
        w.target  = A_ST0;
      end
      A_ADV: begin
        w.cond   = C_NOT_R1;
        w.target = A_R2;
      end
      A_R1CHK: begin
        w.cond   = C_XS_GE_YS;
        w.target = A_SW0;
      end
      A_R1A: w.walk = WALK_R1A;
      A_R1B: begin
        w.walk   = WALK_R1B;
        w.emit   = EMIT_POINT;
        w.cond   = C_ALWAYS;
        w.target = A_WAIT;
      end
      A_SW0: begin
        w.ma = OP_AODD;
        w.mb = OP_AODD;
      end
      A_SW1: begin
        w.wr_t = 1'b1;
        w.ma   = OP_BTERM;
        w.mb   = OP_BTERM;
      end
      A_SW2: begin
        w.wr_t = 1'b1;
        w.ma   = OP_RY2;
        w.mb   = OP_T;
      end
      A_SW3: begin
        w.acc_op = ACC_LOAD;
        w.ma     = OP_RX2;
        w.mb     = OP_T;
      end
      A_SW4: begin
        w.acc_op   = ACC_ADD;
        w.acc_shl2 = 1'b1;
        w.ma       = OP_RX2;
        w.mb       = OP_RY2;
      end
      A_SW5: begin
        w.acc_op   = ACC_ADD;
        w.acc_shl2 = 1'b1;
        w.acc_neg  = 1'b1;
      end
      A_SW6: begin
        w.d_load    = 1'b1;
        w.set_phase = 1'b1;
        w.phase_val = PH_R2;
      end
      A_R2: begin
        w.cond   = C_NOT_R2;
        w.target = A_DONE;
      end
      A_R2CHK: begin
        w.cond   = C_Y_ZERO;
        w.target = A_DONE;
      end
      A_R2A: w.walk = WALK_R2A;
      A_R2B: begin
        w.walk   = WALK_R2B;
        w.emit   = EMIT_POINT;
        w.cond   = C_ALWAYS;
        w.target = A_WAIT;
      end
      A_DONE: begin
        w.set_phase = 1'b1;
        w.phase_val = PH_DONE;
        w.emit      = EMIT_DONE;
        w.cond      = C_ALWAYS;
        w.target    = A_WAIT;
      end
      A_ST0: begin
        w.ma = OP_RX;
        w.mb = OP_RX;
      end
      A_ST1: begin
        w.wr_rx2 = 1'b1;
        w.ma     = OP_RY;
        w.mb     = OP_RY;
      end
      A_ST2: begin
        w.wr_ry2 = 1'b1;
        w.ma     = OP_RX2;
        w.mb     = OP_RY;
      end
      A_ST3: begin
        w.ys_load  = 1'b1;
        w.acc_op   = ACC_LOAD;
        w.acc_neg  = 1'b1;
        w.acc_shl2 = 1'b1;
        w.ma       = OP_RY2;
        w.mb       = OP_ONE;
      end
      A_ST4: begin
        w.acc_op   = ACC_ADD;
        w.acc_shl2 = 1'b1;
        w.ma       = OP_RX2;
        w.mb       = OP_ONE;
      end
      A_ST5: w.acc_op = ACC_ADD;
      A_ST6: begin
        w.d_load    = 1'b1;
        w.set_phase = 1'b1;
        w.phase_val = PH_R1;
        w.emit      = EMIT_POINT;
        w.cond      = C_ALWAYS;
        w.target    = A_WAIT;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = A_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

### rtl/mer_if.sv
interface mer_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [mer_pkg::CTR_W-1:0]   center_x;
  logic [mer_pkg::CTR_W-1:0]   center_y;
  logic [mer_pkg::RAD_W-1:0]   radius_x;
  logic [mer_pkg::RAD_W-1:0]   radius_y;

  modport source(output valid, operation, center_x, center_y, radius_x, radius_y,
                 input ready);
  modport sink(input valid, operation, center_x, center_y, radius_x, radius_y,
               output ready);
endinterface

interface mer_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [mer_pkg::COORD_W-1:0] right_x;
  logic signed [mer_pkg::COORD_W-1:0] left_x;
  logic signed [mer_pkg::COORD_W-1:0] lower_y;
  logic signed [mer_pkg::COORD_W-1:0] upper_y;
  logic                               point_valid;
  logic                               finished;

  modport source(output valid, right_x, left_x, lower_y, upper_y, point_valid, finished,
                 input ready);
  modport sink(input valid, right_x, left_x, lower_y, upper_y, point_valid, finished,
               output ready);
endinterface

### rtl/mer_sequencer.sv
module mer_sequencer (
  input  logic           clk,
  input  logic           rst,
  input  mer_pkg::stat_t stat,
  output mer_pkg::ctl_t  ctl
);

  logic [mer_pkg::PC_W-1:0] pc;
  mer_pkg::uc_t             word;
  logic                     en;
  logic                     take;

  assign word = mer_pkg::uc_rom(pc);

  // hold the step while waiting for an input beat or for the result slot
  assign en = !(word.wait_in && !stat.in_valid) &&
              !((word.emit != mer_pkg::EMIT_NONE) && stat.out_busy);

  always_comb begin
    case (word.cond)
      mer_pkg::C_NEVER:    take = 1'b0;
      mer_pkg::C_ALWAYS:   take = 1'b1;
      mer_pkg::C_IN_START: take = stat.in_start;
      mer_pkg::C_NOT_R1:   take = stat.not_r1;
      mer_pkg::C_NOT_R2:   take = stat.not_r2;
      mer_pkg::C_XS_GE_YS: take = stat.xs_ge_ys;
      mer_pkg::C_Y_ZERO:   take = stat.y_zero;
      default:             take = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= mer_pkg::A_WAIT;
    end else if (en) begin
      pc <= take ? word.target : pc + mer_pkg::PC_W'(1);
    end
  end

  assign ctl.word = word;
  assign ctl.en   = en;

  a_stall_holds_pc: assert property (@(posedge clk) disable iff (rst)
    !en |=> pc == $past(pc))
    else $error("sequencer moved while stalled");

  a_wait_only_at_dispatch: assert property (@(posedge clk) disable iff (rst)
    word.wait_in |-> pc == mer_pkg::A_WAIT)
    else $error("input wait outside dispatch step");

  a_emit_returns: assert property (@(posedge clk) disable iff (rst)
    (en && word.emit != mer_pkg::EMIT_NONE) |=> pc == mer_pkg::A_WAIT)
    else $error("sequencer did not return to dispatch after a result");

endmodule

### rtl/mer_datapath.sv
module mer_datapath (
  input  logic          clk,
  input  logic          rst,
  input  mer_pkg::ctl_t ctl,
  output mer_pkg::stat_t stat,
  mer_in_if.sink        request,
  mer_out_if.source     result
);

  logic [mer_pkg::CTR_W-1:0]   cx;
  logic [mer_pkg::CTR_W-1:0]   cy;
  logic [mer_pkg::RAD_W-1:0]   rx;
  logic [mer_pkg::RAD_W-1:0]   ry;
  logic [mer_pkg::SQ_W-1:0]    rx2;
  logic [mer_pkg::SQ_W-1:0]    ry2;
  logic [mer_pkg::XOFF_W-1:0]  x;
  logic [mer_pkg::RAD_W-1:0]   y;
  logic [mer_pkg::TERM_W-1:0]  xs;
  logic [mer_pkg::TERM_W-1:0]  ys;
  logic signed [mer_pkg::DEC_W-1:0] d;
  logic signed [mer_pkg::DEC_W-1:0] acc;
  logic [mer_pkg::PROD_W-1:0]  p;
  logic [mer_pkg::MUL_W-1:0]   t;
  logic                        flag;
  mer_pkg::phase_t             phase;

  logic                               out_valid;
  logic signed [mer_pkg::COORD_W-1:0] out_rx;
  logic signed [mer_pkg::COORD_W-1:0] out_lx;
  logic signed [mer_pkg::COORD_W-1:0] out_ly;
  logic signed [mer_pkg::COORD_W-1:0] out_uy;
  logic                               out_pt;
  logic                               out_fin;

  logic [mer_pkg::MUL_W-1:0]   opv [8];
  logic [mer_pkg::MUL_W-1:0]   ma_v;
  logic [mer_pkg::MUL_W-1:0]   mb_v;
  logic [mer_pkg::PROD_W-1:0]  prod;
  logic [mer_pkg::DEC_W-1:0]   term;
  logic [mer_pkg::DEC_W-1:0]   acc_base;
  logic signed [mer_pkg::DEC_W-1:0] quarter;
  logic [mer_pkg::RAD_W-1:0]   bterm;
  logic [mer_pkg::TERM_W-1:0]  rx2_dbl;
  logic [mer_pkg::TERM_W-1:0]  ry2_dbl;
  logic                        d_neg;
  logic                        d_pos;
  logic                        accept;
  logic                        en;
  mer_pkg::uc_t                w;

  assign w  = ctl.word;
  assign en = ctl.en;

  // multiplier operand sources
  assign opv[mer_pkg::OP_ONE]   = mer_pkg::MUL_W'(1);
  assign opv[mer_pkg::OP_RX]    = mer_pkg::MUL_W'(rx);
  assign opv[mer_pkg::OP_RY]    = mer_pkg::MUL_W'(ry);
  assign opv[mer_pkg::OP_RX2]   = mer_pkg::MUL_W'(rx2);
  assign opv[mer_pkg::OP_RY2]   = mer_pkg::MUL_W'(ry2);
  assign opv[mer_pkg::OP_T]     = t;
  assign opv[mer_pkg::OP_AODD]  = mer_pkg::MUL_W'({x, 1'b1});
  assign opv[mer_pkg::OP_BTERM] = mer_pkg::MUL_W'(bterm);

  assign bterm   = (y != '0) ? y - mer_pkg::RAD_W'(1) : mer_pkg::RAD_W'(1);
  assign ma_v    = opv[w.ma];
  assign mb_v    = opv[w.mb];
  assign prod    = mer_pkg::PROD_W'(ma_v) * mer_pkg::PROD_W'(mb_v);
  assign rx2_dbl = mer_pkg::TERM_W'({rx2, 1'b0});
  assign ry2_dbl = mer_pkg::TERM_W'({ry2, 1'b0});
  assign d_neg   = d[mer_pkg::DEC_W-1];
  assign d_pos   = !d_neg && (d != '0);

  assign term     = w.acc_shl2 ? mer_pkg::DEC_W'({p, 2'b00}) : mer_pkg::DEC_W'(p);
  assign acc_base = (w.acc_op == mer_pkg::ACC_LOAD) ? '0 : acc;

  // quarter units back to integer, truncating toward zero
  assign quarter = acc[mer_pkg::DEC_W-1] ?
                   ($signed(acc + mer_pkg::DEC_W'(3)) >>> 2) : (acc >>> 2);

  assign accept = en && w.wait_in && request.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= mer_pkg::PH_DONE;
      x     <= '0;
      y     <= '0;
      xs    <= '0;
      ys    <= '0;
    end else if (en) begin
      if (accept && request.operation == mer_pkg::OPER_START) begin
        cx <= mer_pkg::sat_center(request.center_x);
        cy <= mer_pkg::sat_center(request.center_y);
        rx <= mer_pkg::sat_radius(request.radius_x);
        ry <= mer_pkg::sat_radius(request.radius_y);
        x  <= '0;
        y  <= mer_pkg::sat_radius(request.radius_y);
        xs <= '0;
      end

      p <= prod;
      if (w.wr_rx2) rx2 <= mer_pkg::SQ_W'(p);
      if (w.wr_ry2) ry2 <= mer_pkg::SQ_W'(p);
      if (w.wr_t)   t   <= mer_pkg::MUL_W'(p);
      if (w.ys_load) ys <= mer_pkg::TERM_W'({p, 1'b0});

      if (w.acc_op != mer_pkg::ACC_HOLD) begin
        acc <= w.acc_neg ? acc_base - term : acc_base + term;
      end
      if (w.d_load) d <= quarter;
      if (w.set_phase) phase <= w.phase_val;

      case (w.walk)
        mer_pkg::WALK_R1A: begin
          flag <= d_neg;
          x    <= x + mer_pkg::XOFF_W'(1);
          xs   <= xs + ry2_dbl;
          if (!d_neg) begin
            y  <= y - mer_pkg::RAD_W'(1);
            ys <= ys - rx2_dbl;
          end
        end
        mer_pkg::WALK_R1B: begin
          d <= d + mer_pkg::DEC_W'(ry2) + mer_pkg::DEC_W'(xs)
                 - (flag ? '0 : mer_pkg::DEC_W'(ys));
        end
        mer_pkg::WALK_R2A: begin
          flag <= d_pos;
          y    <= y - mer_pkg::RAD_W'(1);
          ys   <= ys - rx2_dbl;
          if (!d_pos) begin
            x  <= x + mer_pkg::XOFF_W'(1);
            xs <= xs + ry2_dbl;
          end
        end
        mer_pkg::WALK_R2B: begin
          d <= d + mer_pkg::DEC_W'(rx2) - mer_pkg::DEC_W'(ys)
                 + (flag ? '0 : mer_pkg::DEC_W'(xs));
        end
        default: ;
      endcase
    end
  end

  // result slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en && w.emit != mer_pkg::EMIT_NONE) begin
      out_valid <= 1'b1;
      if (w.emit == mer_pkg::EMIT_POINT) begin
        out_rx  <= $signed(mer_pkg::COORD_W'(cx) + mer_pkg::COORD_W'(x));
        out_lx  <= $signed(mer_pkg::COORD_W'(cx) - mer_pkg::COORD_W'(x));
        out_ly  <= $signed(mer_pkg::COORD_W'(cy) + mer_pkg::COORD_W'(y));
        out_uy  <= $signed(mer_pkg::COORD_W'(cy) - mer_pkg::COORD_W'(y));
        out_pt  <= 1'b1;
        out_fin <= 1'b0;
      end else begin
        out_rx  <= '0;
        out_lx  <= '0;
        out_ly  <= '0;
        out_uy  <= '0;
        out_pt  <= 1'b0;
        out_fin <= 1'b1;
      end
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign request.ready      = w.wait_in;
  assign result.valid       = out_valid;
  assign result.right_x     = out_rx;
  assign result.left_x      = out_lx;
  assign result.lower_y     = out_ly;
  assign result.upper_y     = out_uy;
  assign result.point_valid = out_pt;
  assign result.finished    = out_fin;

  assign stat.in_valid = request.valid;
  assign stat.in_start = (request.operation == mer_pkg::OPER_START);
  assign stat.out_busy = out_valid && !result.ready;
  assign stat.not_r1   = (phase != mer_pkg::PH_R1);
  assign stat.not_r2   = (phase != mer_pkg::PH_R2);
  assign stat.xs_ge_ys = (xs >= ys);
  assign stat.y_zero   = (y == '0);

  // a start reloads the walk before the phase changes, so check only at dispatch
  a_r2_terms: assert property (@(posedge clk) disable iff (rst)
    (phase == mer_pkg::PH_R2 && w.wait_in) |-> xs >= ys)
    else $error("region 2 entered with x step term below y step term");

  a_done_at_axis: assert property (@(posedge clk) disable iff (rst)
    (phase == mer_pkg::PH_DONE && w.wait_in) |-> y == '0)
    else $error("walk finished off the x axis");

  a_emit_fills_slot: assert property (@(posedge clk) disable iff (rst)
    (en && w.emit != mer_pkg::EMIT_NONE) |=> result.valid)
    else $error("result step did not fill the output slot");

endmodule

### rtl/midpoint_ellipse_rasterizer.sv
// Start: a beat runs dispatch + 7 microcode steps; the last step emits the result.
// Advance in region 1: dispatch, phase check, switch check and two walk steps; region 2:
// dispatch, two phase checks, axis check and two walk steps. The region switch adds the check
// and 7 multiply-accumulate steps on the one shared multiplier. A new beat is taken only at the
// dispatch step; a result step stalls while the output register still holds an unaccepted beat.
// Reset (synchronous): step counter to dispatch, walk finished, offsets zero.
module midpoint_ellipse_rasterizer (
  input logic       clk,
  input logic       rst,
  mer_in_if.sink    request,
  mer_out_if.source result
);

  mer_pkg::ctl_t  ctl;
  mer_pkg::stat_t stat;

  mer_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  mer_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .stat    (stat),
    .request (request),
    .result  (result)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam logic OPER_ADVANCE = ~mer_pkg::OPER_START;
  localparam int   CYCLE_LIMIT  = 500000;
  localparam int   TAIL_CYCLES  = 40;

  typedef struct packed {
    logic                      op;
    logic [mer_pkg::CTR_W-1:0] cx;
    logic [mer_pkg::CTR_W-1:0] cy;
    logic [mer_pkg::RAD_W-1:0] rx;
    logic [mer_pkg::RAD_W-1:0] ry;
  } draw_cmd_t;

  localparam int CMD_W = $bits(draw_cmd_t);

  typedef struct packed {
    logic [mer_pkg::COORD_W-1:0] right_x;
    logic [mer_pkg::COORD_W-1:0] left_x;
    logic [mer_pkg::COORD_W-1:0] lower_y;
    logic [mer_pkg::COORD_W-1:0] upper_y;
    logic                        point_valid;
    logic                        finished;
  } pixel_set_t;

  logic clk;
  logic rst;

  mer_in_if  request_if ();
  mer_out_if result_if ();

  midpoint_ellipse_rasterizer u_top (
    .clk     (clk),
    .rst     (rst),
    .request (request_if),
    .result  (result_if)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // walk state mirrored on the testbench side
  longint org_x, org_y;
  longint span_x, span_y;
  longint x_term, y_term;
  longint rx_sq, ry_sq;
  longint decision_q;
  mer_pkg::phase_t walk_phase;

  draw_cmd_t  cmd_queue[$];
  pixel_set_t pixel_sets_due[$];
  draw_cmd_t  next_cmd;
  draw_cmd_t  taken_cmd;
  pixel_set_t want;

  int   send_gap_pct;
  int   recv_gap_pct;
  logic in_took;
  int   errors;
  int   cycles;
  int   starts_sent, advances_sent, points_seen, finishes_seen;

  function automatic pixel_set_t trace_ellipse(input draw_cmd_t c);
    pixel_set_t p;
    longint     rxl, ryl, a, b;
    logic       stepped;
    rxl = c.rx;
    ryl = c.ry;
    stepped = 1'b0;
    if (c.op == mer_pkg::OPER_START) begin
      // fields cannot exceed the saturation limits at these widths
      org_x = (c.cx > mer_pkg::CENTER_MAX) ? mer_pkg::CENTER_MAX : c.cx;
      org_y = (c.cy > mer_pkg::CENTER_MAX) ? mer_pkg::CENTER_MAX : c.cy;
      if (rxl > mer_pkg::RADIUS_MAX) rxl = mer_pkg::RADIUS_MAX;
      if (ryl > mer_pkg::RADIUS_MAX) ryl = mer_pkg::RADIUS_MAX;
      rx_sq = rxl * rxl;
      ry_sq = ryl * ryl;
      span_x = 0;
      span_y = ryl;
      x_term = 0;
      y_term = 2 * rx_sq * ryl;
      // quarter units, signed divide truncates toward zero
      decision_q = (4 * ry_sq - 4 * rx_sq * ryl + rx_sq) / 4;
      walk_phase = mer_pkg::PH_R1;
      stepped = 1'b1;
    end else begin
      if (walk_phase == mer_pkg::PH_R1) begin
        if (x_term < y_term) begin
          span_x = span_x + 1;
          x_term = x_term + 2 * ry_sq;
          if (decision_q < 0) begin
            decision_q = decision_q + ry_sq + x_term;
          end else begin
            span_y = span_y - 1;
            y_term = y_term - 2 * rx_sq;
            decision_q = decision_q + ry_sq + x_term - y_term;
          end
          stepped = 1'b1;
        end else begin
          a = 2 * span_x + 1;
          b = (span_y != 0) ? span_y - 1 : 1;
          decision_q = (ry_sq * a * a + 4 * rx_sq * b * b - 4 * rx_sq * ry_sq) / 4;
          walk_phase = mer_pkg::PH_R2;
        end
      end
      if (!stepped && walk_phase == mer_pkg::PH_R2) begin
        if (span_y > 0) begin
          span_y = span_y - 1;
          y_term = y_term - 2 * rx_sq;
          if (decision_q > 0) begin
            decision_q = decision_q + rx_sq - y_term;
          end else begin
            span_x = span_x + 1;
            x_term = x_term + 2 * ry_sq;
            decision_q = decision_q + rx_sq - y_term + x_term;
          end
          stepped = 1'b1;
        end else begin
          walk_phase = mer_pkg::PH_DONE;
        end
      end
    end
    p = '0;
    if (stepped) begin
      p.right_x     = mer_pkg::COORD_W'(org_x + span_x);
      p.left_x      = mer_pkg::COORD_W'(org_x - span_x);
      p.lower_y     = mer_pkg::COORD_W'(org_y + span_y);
      p.upper_y     = mer_pkg::COORD_W'(org_y - span_y);
      p.point_valid = 1'b1;
    end else begin
      p.finished = 1'b1;
    end
    return p;
  endfunction

  task automatic check_field(input string name, input logic [mer_pkg::COORD_W-1:0] exp_v,
                             input logic [mer_pkg::COORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name,
               $signed(exp_v), $signed(act_v));
    end
  endtask

  // sender
  always @(negedge clk) begin
    if (!rst) begin
      if (!request_if.valid || in_took) begin
        if (cmd_queue.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          next_cmd = cmd_queue.pop_front();
          request_if.valid     <= 1'b1;
          request_if.operation <= next_cmd.op;
          request_if.center_x  <= next_cmd.cx;
          request_if.center_y  <= next_cmd.cy;
          request_if.radius_x  <= next_cmd.rx;
          request_if.radius_y  <= next_cmd.ry;
        end else begin
          request_if.valid <= 1'b0;
        end
      end
      result_if.ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // acceptance, prediction and checking
  always @(posedge clk) begin
    in_took <= request_if.valid && request_if.ready;
    if (!rst) begin
      if (result_if.valid && result_if.ready) begin
        if (pixel_sets_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none, got %0d %0d %0d %0d pv=%0b fin=%0b",
                   $time, result_if.right_x, result_if.left_x, result_if.lower_y,
                   result_if.upper_y, result_if.point_valid, result_if.finished);
        end else begin
          want = pixel_sets_due.pop_front();
          check_field("right_x", want.right_x, result_if.right_x);
          check_field("left_x", want.left_x, result_if.left_x);
          check_field("lower_y", want.lower_y, result_if.lower_y);
          check_field("upper_y", want.upper_y, result_if.upper_y);
          check_field("point_valid", mer_pkg::COORD_W'(want.point_valid),
                      mer_pkg::COORD_W'(result_if.point_valid));
          check_field("finished", mer_pkg::COORD_W'(want.finished),
                      mer_pkg::COORD_W'(result_if.finished));
          if (want.point_valid) points_seen++;
          if (want.finished) finishes_seen++;
        end
      end
      if (request_if.valid && request_if.ready) begin
        taken_cmd.op = request_if.operation;
        taken_cmd.cx = request_if.center_x;
        taken_cmd.cy = request_if.center_y;
        taken_cmd.rx = request_if.radius_x;
        taken_cmd.ry = request_if.radius_y;
        pixel_sets_due.push_back(trace_ellipse(taken_cmd));
        if (taken_cmd.op == mer_pkg::OPER_START) starts_sent++;
        else advances_sent++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d beats still due", $time, pixel_sets_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_start(input int cx, input int cy, input int rx, input int ry);
    draw_cmd_t c;
    c.op = mer_pkg::OPER_START;
    c.cx = mer_pkg::CTR_W'(cx);
    c.cy = mer_pkg::CTR_W'(cy);
    c.rx = mer_pkg::RAD_W'(rx);
    c.ry = mer_pkg::RAD_W'(ry);
    cmd_queue.push_back(c);
  endtask

  // advance beats carry random don't-care payload
  task automatic push_advance(input int n);
    draw_cmd_t c;
    for (int i = 0; i < n; i++) begin
      c.op = OPER_ADVANCE;
      c.cx = mer_pkg::CTR_W'($urandom);
      c.cy = mer_pkg::CTR_W'($urandom);
      c.rx = mer_pkg::RAD_W'($urandom);
      c.ry = mer_pkg::RAD_W'($urandom);
      cmd_queue.push_back(c);
    end
  endtask

  task automatic queue_random_walks(input int budget);
    int        made, sel, rx, ry, n;
    draw_cmd_t c;
    made = 0;
    while (made < budget) begin
      sel = $urandom_range(99);
      if (sel < 10) begin
        // noise: stray beats of either kind
        n = $urandom_range(4, 1);
        for (int i = 0; i < n; i++) begin
          c = draw_cmd_t'(CMD_W'({$urandom, $urandom}));
          cmd_queue.push_back(c);
        end
        made += n;
      end else begin
        if (sel < 72) begin
          rx = $urandom_range(24);
          ry = $urandom_range(24);
          n  = rx + ry + 1 + $urandom_range(3);
        end else if (sel < 86) begin
          rx = $urandom_range(mer_pkg::RADIUS_MAX);
          ry = $urandom_range(mer_pkg::RADIUS_MAX);
          n  = $urandom_range(30);
        end else if (sel < 93) begin
          // thin ellipse, either orientation
          if ($urandom_range(1)) begin
            rx = $urandom_range(mer_pkg::RADIUS_MAX);
            ry = $urandom_range(4);
          end else begin
            rx = $urandom_range(4);
            ry = $urandom_range(mer_pkg::RADIUS_MAX);
          end
          n = $urandom_range(60);
        end else begin
          rx = $urandom_range(80);
          ry = $urandom_range(80);
          n  = $urandom_range(rx + ry + 4);
        end
        push_start($urandom_range(mer_pkg::CENTER_MAX), $urandom_range(mer_pkg::CENTER_MAX),
                   rx, ry);
        push_advance(n);
        made += n + 1;
      end
    end
  endtask

  task automatic wait_drained();
    while (cmd_queue.size() != 0 || request_if.valid || pixel_sets_due.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    request_if.valid     = 1'b0;
    request_if.operation = OPER_ADVANCE;
    request_if.center_x  = '0;
    request_if.center_y  = '0;
    request_if.radius_x  = '0;
    request_if.radius_y  = '0;
    result_if.ready      = 1'b0;
    in_took       = 1'b0;
    errors        = 0;
    cycles        = 0;
    starts_sent   = 0;
    advances_sent = 0;
    points_seen   = 0;
    finishes_seen = 0;
    send_gap_pct  = 14;
    recv_gap_pct  = 67;
    span_x = 0;
    span_y = 0;
    x_term = 0;
    y_term = 0;
    rx_sq = 0;
    ry_sq = 0;
    org_x = 0;
    org_y = 0;
    decision_q = 0;
    walk_phase = mer_pkg::PH_DONE;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // advance straight out of reset reports finished
    push_advance(1);
    // zero radii: center point, then finished twice
    push_start(0, 0, 0, 0);
    push_advance(2);
    // largest center and radii, lower_y runs past the center range
    push_start(mer_pkg::CENTER_MAX, mer_pkg::CENTER_MAX, mer_pkg::RADIUS_MAX,
               mer_pkg::RADIUS_MAX);
    push_advance(2);
    // negative left_x, then abandoned by a new start
    push_start(0, 0, mer_pkg::RADIUS_MAX, 1);
    push_advance(3);
    // negative upper_y, flat in x
    push_start(mer_pkg::CENTER_MAX, 0, 0, mer_pkg::RADIUS_MAX);
    push_advance(3);
    // small ellipse run through both regions to the end
    push_start(512, 512, 3, 2);
    push_advance(7);
    wait_drained();

    queue_random_walks(350);
    wait_drained();

    send_gap_pct = 67;
    recv_gap_pct = 14;
    queue_random_walks(350);
    wait_drained();

    send_gap_pct = 0;
    recv_gap_pct = 0;
    // one large ellipse walked to completion, deep into region 2
    begin
      int brx, bry;
      brx = $urandom_range(mer_pkg::RADIUS_MAX, 300);
      bry = $urandom_range(250, 100);
      push_start($urandom_range(mer_pkg::CENTER_MAX), $urandom_range(mer_pkg::CENTER_MAX),
                 brx, bry);
      push_advance(brx + bry + 2);
    end
    queue_random_walks(150);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d start beats and %0d advance beats;", starts_sent,
             advances_sent);
    $display("checked %0d point sets and %0d end-of-walk reports, %0d errors.",
             points_seen, finishes_seen, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
